// ----- design/rollback_send_list_unit_macros.svh -----
// Assertion macros used by the send list top level.
`ifndef ROLLBACK_SEND_LIST_UNIT_MACROS_SVH
`define ROLLBACK_SEND_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RBSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("send list check failed");
`define RBSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("send list check failed");
`else
`define RBSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RBSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/rbsl_pkg.sv -----
// Types, codes and defaults shared by the send list design files.
package rbsl_pkg;

    localparam int LIST_DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_ROLLBACK = 2'd1,
        ACT_CLEAR    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RANGE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_REMOVED = 3'd2,
        ST_NONE    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  message_kind;
        logic [7:0]  process_id;
        logic [31:0] sim_time;
        logic [15:0] message_handle;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  out_kind;
        logic [7:0]  out_process;
        logic [31:0] out_time;
        logic [15:0] out_handle;
        logic [5:0]  removed_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  process;
        logic [31:0] time_stamp;
        logic [15:0] handle;
    } t_entry;

    function automatic t_result removed_result(input t_entry entry, input logic last);
        t_result res;
        res               = '0;
        res.status        = ST_REMOVED;
        res.out_kind      = entry.kind;
        res.out_process   = entry.process;
        res.out_time      = entry.time_stamp;
        res.out_handle    = entry.handle;
        res.last          = last;
        return res;
    endfunction

endpackage

// ----- design/rbsl_mem.sv -----
// Entry store: one write port, one read port with registered read data.
module rbsl_mem #(
    parameter int LIST_DEPTH = rbsl_pkg::LIST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(LIST_DEPTH)-1:0] i_wr_addr,
    input  rbsl_pkg::t_entry              i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(LIST_DEPTH)-1:0] i_rd_addr,
    output rbsl_pkg::t_entry              o_rd_data
);
    import rbsl_pkg::*;

    t_entry r_mem [LIST_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/rollback_send_list_unit.sv -----
// Top level of the ordered send list with add, rollback and clear requests.
//
//  Channel  | Ports                          | Handshake
//  ---------+--------------------------------+--------------------------------
//  request  | i_start, i_request, o_busy     | taken when i_start and !o_busy
//  result   | o_strobe, o_result             | one-cycle strobe per result, no stall
//
// An add request gives its result in the next cycle and leaves the block idle.
// A rollback or clear request scans the store one entry per cycle and compacts
// survivors in place; the block stays busy until the scan is done.
// Removed entries of a rollback appear during the scan; the final result, with
// last set, appears as busy drops. Reset empties the list at once with no
// clearing pass. Results cannot be stalled.
`include "rollback_send_list_unit_macros.svh"
module rollback_send_list_unit #(
    parameter int LIST_DEPTH = rbsl_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rbsl_pkg::t_request i_request,
    output logic               o_busy,
    output logic               o_strobe,
    output rbsl_pkg::t_result  o_result
);
    import rbsl_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_keep, n_keep;
    logic              r_rd_v, n_rd_v;
    logic              r_pend_v, n_pend_v;
    t_entry            r_pend, n_pend;
    logic              r_is_clear, n_is_clear;
    logic [7:0]        r_proc, n_proc;
    logic [31:0]       r_time, n_time;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    t_entry            rd_data;
    logic              rb_hit;
    logic              clr_hit;
    logic              hit;
    logic [CNT_W-1:0]  removed_n;
    logic [CNT_W+5:0]  removed_ext;

    rbsl_mem #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rb_hit = (rd_data.process == r_proc) &&
                    ((((rd_data.kind == KIND_READ) || (rd_data.kind == KIND_RANGE)) &&
                      (rd_data.time_stamp >= r_time)) ||
                     ((rd_data.kind == KIND_WRITE) && (rd_data.time_stamp > r_time)));
    assign clr_hit     = rd_data.time_stamp < r_time;
    assign hit         = r_is_clear ? clr_hit : rb_hit;
    assign removed_n   = r_count - r_keep;
    assign removed_ext = {6'd0, removed_n};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_keep     = r_keep;
        n_rd_v     = r_rd_v;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_is_clear = r_is_clear;
        n_proc     = r_proc;
        n_time     = r_time;
        n_strobe   = 1'b0;
        n_result   = '0;
        wr_en      = 1'b0;
        wr_addr    = r_keep[IDX_W-1:0];
        wr_data    = rd_data;
        rd_en      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_request.action)
                        ACT_ADD: begin
                            n_strobe      = 1'b1;
                            n_result.last = 1'b1;
                            if (r_count == CNT_W'(LIST_DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                wr_en              = 1'b1;
                                wr_addr            = r_count[IDX_W-1:0];
                                wr_data.kind       = i_request.message_kind;
                                wr_data.process    = i_request.process_id;
                                wr_data.time_stamp = i_request.sim_time;
                                wr_data.handle     = i_request.message_handle;
                                n_count            = r_count + 1'b1;
                                n_result.status    = ST_ADDED;
                            end
                        end
                        ACT_ROLLBACK, ACT_CLEAR: begin
                            n_state    = S_SCAN;
                            n_is_clear = (i_request.action == ACT_CLEAR);
                            n_proc     = i_request.process_id;
                            n_time     = i_request.sim_time;
                            n_rd_idx   = '0;
                            n_keep     = '0;
                            n_rd_v     = 1'b0;
                            n_pend_v   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_count) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_rd_v   = 1'b1;
                end else begin
                    n_rd_v = 1'b0;
                end
                if (r_rd_v) begin
                    if (hit) begin
                        if (!r_is_clear) begin
                            if (r_pend_v) begin
                                n_strobe = 1'b1;
                                n_result = removed_result(r_pend, 1'b0);
                            end
                            n_pend   = rd_data;
                            n_pend_v = 1'b1;
                        end
                    end else begin
                        wr_en  = 1'b1;
                        n_keep = r_keep + 1'b1;
                    end
                end else if (r_rd_idx == r_count) begin
                    n_state  = S_IDLE;
                    n_count  = r_keep;
                    n_strobe = 1'b1;
                    if (r_is_clear) begin
                        n_result.status        = ST_CLEARED;
                        n_result.removed_count = removed_ext[5:0];
                        n_result.last          = 1'b1;
                    end else if (r_pend_v) begin
                        n_result = removed_result(r_pend, 1'b1);
                    end else begin
                        n_result.status = ST_NONE;
                        n_result.last   = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_v   <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_v   <= n_rd_v;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_keep     <= n_keep;
        r_pend     <= n_pend;
        r_is_clear <= n_is_clear;
        r_proc     <= n_proc;
        r_time     <= n_time;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `RBSL_ASSERT_NXT(a_request_answered, i_clk, i_rst_n,
        i_start && !o_busy && ((i_request.action == ACT_ADD) ||
        (i_request.action == ACT_ROLLBACK) || (i_request.action == ACT_CLEAR)),
        o_strobe || o_busy)
    `RBSL_ASSERT_IMP(a_keep_behind_read, i_clk, i_rst_n,
        r_state == S_SCAN, (r_keep <= r_rd_idx) && (r_rd_idx <= r_count))
    `RBSL_ASSERT_IMP(a_last_ends_busy, i_clk, i_rst_n,
        o_strobe, o_result.last == !o_busy)

endmodule

// ----- dv/rollback_send_list_checker.sv -----
// Send list checker: predicts every request's results and compares them as they appear.
module rollback_send_list_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rbsl_pkg::t_request i_request,
    input  logic               i_busy,
    input  logic               i_strobe,
    input  rbsl_pkg::t_result  i_result,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_results
);
    import rbsl_pkg::*;

    t_entry  sent_list [LIST_DEPTH_DEF];
    int      sent_len = 0;
    t_result expected_q [$];
    t_result want;
    int      mismatches = 0;
    int      results_seen = 0;

    function automatic t_result summary_result(input t_status status, input logic [5:0] count);
        t_result res;
        res               = '0;
        res.status        = status;
        res.removed_count = count;
        res.last          = 1'b1;
        return res;
    endfunction

    function automatic logic is_rolled_back(input t_entry entry, input logic [7:0] pid,
                                            input logic [31:0] boundary);
        if (entry.process != pid) begin
            return 1'b0;
        end
        unique case (entry.kind)
            KIND_READ, KIND_RANGE: return entry.time_stamp >= boundary;
            KIND_WRITE:            return entry.time_stamp > boundary;
            default:               return 1'b0;
        endcase
    endfunction

    task automatic predict_request(input t_request req);
        t_result res;
        t_entry  entry;
        int      kept;
        int      first;
        kept  = 0;
        first = expected_q.size();
        unique case (req.action)
            ACT_ADD: begin
                if (sent_len >= LIST_DEPTH_DEF) begin
                    expected_q.insert(expected_q.size(), summary_result(ST_FULL, '0));
                end else begin
                    entry.kind          = req.message_kind;
                    entry.process       = req.process_id;
                    entry.time_stamp    = req.sim_time;
                    entry.handle        = req.message_handle;
                    sent_list[sent_len] = entry;
                    sent_len++;
                    expected_q.insert(expected_q.size(), summary_result(ST_ADDED, '0));
                end
            end
            ACT_ROLLBACK: begin
                for (int i = 0; i < sent_len; i++) begin
                    if (is_rolled_back(sent_list[i], req.process_id, req.sim_time)) begin
                        res             = '0;
                        res.status      = ST_REMOVED;
                        res.out_kind    = sent_list[i].kind;
                        res.out_process = sent_list[i].process;
                        res.out_time    = sent_list[i].time_stamp;
                        res.out_handle  = sent_list[i].handle;
                        expected_q.insert(expected_q.size(), res);
                    end else begin
                        sent_list[kept] = sent_list[i];
                        kept++;
                    end
                end
                sent_len = kept;
                if (expected_q.size() == first) begin
                    expected_q.insert(expected_q.size(), summary_result(ST_NONE, '0));
                end else begin
                    expected_q[expected_q.size() - 1].last = 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < sent_len; i++) begin
                    if (!(sent_list[i].time_stamp < req.sim_time)) begin
                        sent_list[kept] = sent_list[i];
                        kept++;
                    end
                end
                expected_q.insert(expected_q.size(),
                                  summary_result(ST_CLEARED, 6'(sent_len - kept)));
                sent_len = kept;
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_value,
                                 input logic [31:0] act_value);
        if (exp_value !== act_value) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_value, act_value);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sent_len = 0;
            expected_q.delete();
        end else begin
            if (i_strobe) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("result with status %0d arrived with nothing expected",
                           i_result.status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_result.status));
                    compare_field("out_kind", 32'(want.out_kind), 32'(i_result.out_kind));
                    compare_field("out_process", 32'(want.out_process),
                                  32'(i_result.out_process));
                    compare_field("out_time", want.out_time, i_result.out_time);
                    compare_field("out_handle", 32'(want.out_handle),
                                  32'(i_result.out_handle));
                    compare_field("removed_count", 32'(want.removed_count),
                                  32'(i_result.removed_count));
                    compare_field("last", 32'(want.last), 32'(i_result.last));
                end
            end
            if (i_start && !i_busy) begin
                predict_request(i_request);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_q.size();
        o_results    <= results_seen;
    end

endmodule

// ----- dv/tb_rollback_send_list_unit.sv -----
// Send list testbench: directed and random requests, with results checked by a predicting checker.
module tb_rollback_send_list_unit;
    import rbsl_pkg::*;

    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         TAIL_CYCLES  = 40;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [1:0] KIND_UNNAMED = 2'd3;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     i_start   = 1'b0;
    t_request i_request = '0;
    logic     o_busy;
    logic     o_strobe;
    t_result  o_result;

    int mismatches;
    int pending;
    int results_seen;

    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          adds_sent      = 0;
    int          rollbacks_sent = 0;
    int          clears_sent    = 0;
    int          others_sent    = 0;
    logic [7:0]  pid_pool [4];
    logic [31:0] recent_times [8];
    int          recent_idx     = 0;
    logic [31:0] time_base;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rollback_send_list_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_request (i_request),
        .o_busy    (o_busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    rollback_send_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_request    (i_request),
        .i_busy       (o_busy),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_request make_request(input logic [1:0] action, input logic [1:0] kind,
                                              input logic [7:0] pid, input logic [31:0] stamp,
                                              input logic [15:0] handle);
        t_request req;
        req.action         = action;
        req.message_kind   = kind;
        req.process_id     = pid;
        req.sim_time       = stamp;
        req.message_handle = handle;
        return req;
    endfunction

    function automatic t_request random_request();
        int          sel;
        logic [31:0] near;
        logic [7:0]  pid;
        logic [1:0]  kind;
        sel  = $urandom_range(0, 99);
        near = recent_times[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
        pid  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pid_pool[$urandom_range(0, 3)];
        kind = ($urandom_range(0, 19) == 0) ? KIND_UNNAMED : 2'($urandom_range(0, 2));
        if (sel < 55) begin
            return make_request(ACT_ADD, kind, pid, time_base + $urandom_range(0, 15),
                                16'($urandom));
        end else if (sel < 80) begin
            return make_request(ACT_ROLLBACK, 2'($urandom), pid, near, 16'($urandom));
        end else if (sel < 92) begin
            return make_request(ACT_CLEAR, 2'($urandom), pid,
                                ($urandom_range(0, 4) == 0) ? time_base : near, 16'($urandom));
        end
        return make_request(2'($urandom), 2'($urandom), 8'($urandom), $urandom, 16'($urandom));
    endfunction

    task automatic send_request(input t_request req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
            if (gap != 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        unique case (req.action)
            ACT_ADD: begin
                adds_sent++;
                recent_times[recent_idx] = req.sim_time;
                recent_idx = (recent_idx + 1) % 8;
            end
            ACT_ROLLBACK: rollbacks_sent++;
            ACT_CLEAR:    clears_sent++;
            default:      others_sent++;
        endcase
        i_request <= req;
        i_start   <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic wait_for_results();
        i_start   <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        time_base = $urandom;
        foreach (pid_pool[k]) pid_pool[k] = 8'($urandom);
        foreach (recent_times[k]) recent_times[k] = time_base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_request(ACT_ROLLBACK, KIND_READ, 8'h00, 32'h0, 16'h0));
        send_request(make_request(ACT_CLEAR, KIND_READ, 8'h00, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(ACT_ADD, KIND_READ, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(ACT_ADD, KIND_WRITE, 8'h00, 32'h0, 16'h0));
        send_request(make_request(ACT_ADD, KIND_RANGE, 8'hA5, 32'd100, 16'h1234));
        send_request(make_request(ACT_ADD, KIND_UNNAMED, 8'hA5, 32'd100, 16'h5A5A));
        send_request(make_request(ACT_ADD, KIND_WRITE, 8'hA5, 32'd100, 16'hA5A5));
        send_request(make_request(ACT_ADD, KIND_READ, 8'hA5, 32'd99, 16'h0F0F));
        send_request(make_request(ACT_ADD, KIND_WRITE, 8'hA5, 32'd101, 16'hF0F0));
        send_request(make_request(ACT_ROLLBACK, KIND_READ, 8'hA5, 32'd100, 16'h0));
        send_request(make_request(ACT_ROLLBACK, KIND_READ, 8'h00, 32'h0, 16'h0));
        send_request(make_request(ACT_ROLLBACK, KIND_READ, 8'hFF, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(ACT_UNUSED, KIND_READ, 8'h00, 32'h0, 16'h0));
        send_request(make_request(ACT_CLEAR, KIND_READ, 8'h00, 32'd100, 16'h0));
        send_request(make_request(ACT_ROLLBACK, KIND_WRITE, 8'hA5, 32'h0, 16'h0));
        send_request(make_request(ACT_CLEAR, KIND_READ, 8'h00, 32'hFFFF_FFFF, 16'h0));
        send_request(make_request(ACT_ADD, KIND_READ, 8'h5A, 32'h8000_0000, 16'h8000));
        send_request(make_request(ACT_CLEAR, KIND_READ, 8'h00, 32'h0, 16'h0));
        send_request(make_request(ACT_UNUSED, KIND_UNNAMED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
        wait_for_results();

        // Fill past capacity with one process, then roll all of it back in one scan.
        for (int i = 0; i < 36; i++) begin
            send_request(make_request(ACT_ADD, 2'($urandom_range(0, 2)),
                                      (i < 32) ? pid_pool[0] : pid_pool[$urandom_range(0, 3)],
                                      time_base + $urandom_range(1, 15), 16'($urandom)));
        end
        send_request(make_request(ACT_ROLLBACK, KIND_READ, pid_pool[0], 32'h0, 16'h0));
        send_request(make_request(ACT_CLEAR, KIND_READ, 8'h00, 32'hFFFF_FFFF, 16'h0));
        wait_for_results();

        for (int i = 0; i < 80; i++) begin
            if (i == 40) begin
                wait_for_results();
            end
            send_request(random_request());
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Requests sent: %0d adds, %0d rollbacks, %0d clears, %0d with an unused action.",
                 adds_sent, rollbacks_sent, clears_sent, others_sent);
        $display("Results compared: %0d, including a full list and a one-process rollback.",
                 results_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- rollback_send_list_unit.f -----
+incdir+design
design/rbsl_pkg.sv
design/rbsl_mem.sv
design/rollback_send_list_unit.sv
dv/rollback_send_list_checker.sv
dv/tb_rollback_send_list_unit.sv
